// ----- rtl/htlp_pkg.sv -----
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants for the linear-probe hash table insert block.
// ----------------------------------------------------------------------------
package htlp_pkg;

    // Table geometry
    localparam int TABLE_DEPTH  = 1024;
    localparam int HANDLE_WIDTH = 32;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int COORD_W  = 32;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;

    // Multiplicative hash constant and x placement in the key
    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam int          X_SHIFT   = 33;

    // Operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_INSERTED  = 2'd0;
    localparam status_t ST_DUPLICATE = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_CLEARED   = 2'd3;

    // One stored slot: valid flag, key and handle
    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic [HANDLE_WIDTH-1:0] handle;
    } slot_t;

endpackage

// ----- rtl/htlp_if.sv -----
// ----------------------------------------------------------------------------
// htlp_if
// Valid/ready channel interfaces for insert requests and results.
// ----------------------------------------------------------------------------

// Request channel: one insert or clear operation per transfer
interface htlp_req_if;
    import htlp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [COORD_W-1:0] chunk_x;
    logic signed [COORD_W-1:0] chunk_y;
    logic                      layer;
    logic [31:0]               entry_ref;

    modport source (output valid, mode, chunk_x, chunk_y, layer, entry_ref,
                    input ready);
    modport sink   (input valid, mode, chunk_x, chunk_y, layer, entry_ref,
                    output ready);
endinterface

// Result channel: one result per request
interface htlp_rsp_if;
    import htlp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  entries_used;

    modport source (output valid, status, slot_index, entries_used,
                    input ready);
    modport sink   (input valid, status, slot_index, entries_used,
                    output ready);
endinterface

// ----- rtl/hash_table_linear_probe_insert_top.sv -----
// ----------------------------------------------------------------------------
// hash_table_linear_probe_insert_top
// Open-addressing hash table with linear probing, insert and clear only.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer: mode 0 inserts the key built from
//   chunk_x, chunk_y and layer with handle entry_ref; mode 1 clears the table.
//   rsp returns one result per request, in order: status, slot_index and the
//   occupied slot count after the operation.
//   cfg_we/cfg_data write table_capacity (slots in use, the hash modulus).
// Sequence (one operation at a time):
//   insert: multiply/add states S_MUL_LO, S_MUL_HI and S_ADD, the 4-bit
//     per cycle remainder unit, then probes of up to capacity slots through
//     the slot RAM (S_ISSUE, S_PROBE), then S_RESP to rsp.valid.
//   reject on full table: straight from the request to S_RESP.
//   clear: a clearing pass over all 1024 slots, one per cycle.
// Reset: the same clearing pass runs; req.ready stays low until it
//   is done. Capacity resets to 1024, the count to zero.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile and a finished result holds until the register frees up.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_insert_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [htlp_pkg::COUNT_W-1:0] cfg_data,
    htlp_req_if.sink                    req,
    htlp_rsp_if.source                  rsp
);
    import htlp_pkg::*;

    // State codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_LO = 4'd1;
    localparam logic [3:0] S_MUL_HI = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_ISSUE  = 4'd5;
    localparam logic [3:0] S_PROBE  = 4'd6;
    localparam logic [3:0] S_RESP   = 4'd7;
    localparam logic [3:0] S_SWEEP  = 4'd8;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Control registers
    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] cap_reg, cap_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]   sweep_idx_reg, sweep_idx_next;
    logic               report_reg, report_next;
    logic [3:0]         div_cnt_reg, div_cnt_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Datapath registers
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [HANDLE_WIDTH-1:0] handle_reg, handle_next;
    logic [63:0]             plo_reg, plo_next;
    logic [31:0]             phi_reg, phi_next;
    logic [COUNT_W-1:0]      rem_reg, rem_next;
    logic [IDX_W-1:0]        probe_idx_reg, probe_idx_next;
    logic [IDX_W-1:0]        chk_idx_reg, chk_idx_next;
    status_t                 res_status_reg, res_status_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    status_t                 rsp_status_reg, rsp_status_next;
    logic [SLOT_W-1:0]       rsp_slot_reg, rsp_slot_next;
    logic [COUNT_W-1:0]      rsp_used_reg, rsp_used_next;

    // Slot RAM
    slot_t             mem [TABLE_DEPTH];
    slot_t             rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_t             mem_wdata;

    logic [COUNT_W-1:0] cap_eff;
    logic [KEY_W-1:0]   req_key;
    logic [IDX_W-1:0]   probe_inc;
    logic [COUNT_W-1:0] div_rem;

    // Saturated capacity and key packing
    assign cap_eff = (cap_reg > DEPTH_C) ? DEPTH_C : cap_reg;
    assign req_key = {req.chunk_x[COORD_W-2:0], {X_SHIFT{1'b0}}}
                   ^ {{(KEY_W-COORD_W-1){1'b0}}, req.chunk_y, 1'b0}
                   ^ {{(KEY_W-1){1'b0}}, req.layer};

    // Next probe slot, wrapping at capacity
    always_comb
    begin
        logic [COUNT_W-1:0] nxt;
        nxt = {1'b0, probe_idx_reg} + COUNT_W'(1);
        probe_inc = (nxt >= cap_eff) ? '0 : nxt[IDX_W-1:0];
    end

    // Remainder unit: four restoring steps per cycle
    always_comb
    begin
        logic [COUNT_W-1:0] r;
        logic [COUNT_W:0]   t;
        r = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            t = {r, plo_reg[63-k]};
            if (t >= {1'b0, cap_eff})
            begin
                t = t - {1'b0, cap_eff};
            end
            r = t[COUNT_W-1:0];
        end
        div_rem = r;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.slot_index   = rsp_slot_reg;
    assign rsp.entries_used = rsp_used_reg;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cfg_we ? cfg_data : cap_reg;
        count_next      = count_reg;
        sweep_idx_next  = sweep_idx_reg;
        report_next     = report_reg;
        div_cnt_next    = div_cnt_reg;
        left_next       = left_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        rem_next        = rem_reg;
        probe_idx_next  = probe_idx_reg;
        chk_idx_next    = chk_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_used_next   = rsp_used_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_waddr       = chk_idx_reg;
        mem_wdata       = '{valid: 1'b1, key: key_reg, handle: handle_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next    = req_key;
                    handle_next = req.entry_ref[HANDLE_WIDTH-1:0];
                    if (req.mode == MODE_CLEAR)
                    begin
                        count_next     = '0;
                        sweep_idx_next = '0;
                        report_next    = 1'b1;
                        state_next     = S_SWEEP;
                    end
                    else if (count_reg >= cap_eff)
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO:
            begin
                plo_next   = {32'b0, key_reg[31:0]} * {32'b0, HASH_MULT};
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                phi_next   = key_reg[63:32] * HASH_MULT;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                plo_next     = {plo_reg[63:32] + phi_reg, plo_reg[31:0]};
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                rem_next     = div_rem;
                plo_next     = {plo_reg[59:0], 4'b0};
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    probe_idx_next = div_rem[IDX_W-1:0];
                    state_next     = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                // read of the home slot goes out this cycle
                chk_idx_next   = probe_idx_reg;
                probe_idx_next = probe_inc;
                left_next      = cap_eff;
                state_next     = S_PROBE;
            end
            S_PROBE:
            begin
                if (!rdata_reg.valid)
                begin
                    mem_we          = 1'b1;
                    count_next      = count_reg + COUNT_W'(1);
                    res_status_next = ST_INSERTED;
                    res_slot_next   = SLOT_W'(chk_idx_reg);
                    state_next      = S_RESP;
                end
                else if (rdata_reg.key == key_reg)
                begin
                    res_status_next = ST_DUPLICATE;
                    res_slot_next   = '0;
                    state_next      = S_RESP;
                end
                else if (left_reg == COUNT_W'(1))
                begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    // next read already issued at probe_idx_reg
                    left_next      = left_reg - COUNT_W'(1);
                    chk_idx_next   = probe_idx_reg;
                    probe_idx_next = probe_inc;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = res_slot_reg;
                    rsp_used_next   = count_reg;
                    state_next      = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                mem_we         = 1'b1;
                mem_waddr      = sweep_idx_reg;
                mem_wdata      = '0;
                sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                if (sweep_idx_reg == LAST_IDX)
                begin
                    res_status_next = ST_CLEARED;
                    res_slot_next   = '0;
                    state_next      = report_reg ? S_RESP : S_IDLE;
                    report_next     = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            cap_reg       <= DEPTH_C;
            count_reg     <= '0;
            sweep_idx_reg <= '0;
            report_reg    <= 1'b0;
            div_cnt_reg   <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            sweep_idx_reg <= sweep_idx_next;
            report_reg    <= report_next;
            div_cnt_reg   <= div_cnt_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        rem_reg        <= rem_next;
        probe_idx_reg  <= probe_idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_used_reg   <= rsp_used_next;
    end

    // Slot RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[probe_idx_reg];
    end

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("occupied count above table depth");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == MODE_CLEAR) |=> count_reg == '0)
        else $error("clear did not zero the count");

    a_insert_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_PROBE) |-> {1'b0, chk_idx_reg} < cap_eff)
        else $error("insert outside the capacity");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !req.ready)
        else $error("request taken during clearing pass");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_PROBE) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not bump the count");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probe hash table insert block. A local
// copy of the table (valid flags, keys, count, capacity) predicts status,
// slot and count for every accepted request. Each result transfer is then
// checked in order against that prediction. Directed tests cover key
// extremes, key aliasing, duplicates, clears and capacity corner values.
// Random phases follow, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import htlp_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int POOL_MAX    = 48;

    // One request as sent on the req channel
    typedef struct {
        logic                      mode;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      layer;
        logic [31:0]               handle;
    } tile_op_t;

    // One expected result
    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] used;
    } table_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    htlp_req_if req_ch ();
    htlp_rsp_if rsp_ch ();

    hash_table_linear_probe_insert_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Shadow table
    logic               shadow_valid [TABLE_DEPTH];
    logic [KEY_W-1:0]   shadow_key   [TABLE_DEPTH];
    int                 shadow_count = 0;
    logic [COUNT_W-1:0] shadow_cap   = COUNT_W'(TABLE_DEPTH);

    table_result_t pending_results [$];
    tile_op_t      key_pool [$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int err_cnt    = 0;
    int op_cnt     = 0;
    int cfg_writes = 0;
    int ins_cnt    = 0;
    int dup_cnt    = 0;
    int full_cnt   = 0;
    int clr_cnt    = 0;
    int cycle_cnt  = 0;

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result backpressure
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Predict one operation and update the shadow table
    function automatic table_result_t predict_table_op(input tile_op_t op);
        table_result_t res;
        int            cap;
        int            home;
        int            idx;
        int            n;
        logic          done;
        logic [63:0]   key;
        logic [63:0]   prod;
        res.status = ST_FULL;
        res.slot   = '0;
        if (op.mode == MODE_CLEAR)
        begin
            for (n = 0; n < TABLE_DEPTH; n++)
                shadow_valid[n] = 1'b0;
            shadow_count = 0;
            res.status   = ST_CLEARED;
        end
        else
        begin
            cap = (shadow_cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_cap);
            // full test comes before the duplicate search
            if (cap != 0 && shadow_count < cap)
            begin
                key  = ({32'd0, op.cx} << X_SHIFT) ^ ({32'd0, op.cy} << 1)
                     ^ {63'd0, op.layer};
                prod = key * {32'd0, HASH_MULT};
                home = int'(prod % 64'(cap));
                done = 1'b0;
                for (n = 0; n < cap && !done; n++)
                begin
                    idx = home + n;
                    if (idx >= cap)
                        idx -= cap;
                    if (shadow_valid[idx])
                    begin
                        if (shadow_key[idx] == key)
                        begin
                            res.status = ST_DUPLICATE;
                            done       = 1'b1;
                        end
                    end
                    else
                    begin
                        shadow_valid[idx] = 1'b1;
                        shadow_key[idx]   = key;
                        shadow_count++;
                        res.status = ST_INSERTED;
                        res.slot   = idx[SLOT_W-1:0];
                        done       = 1'b1;
                    end
                end
            end
        end
        res.used = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // Send one request; record its expected result at the transfer
    task automatic send_op(input tile_op_t op);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= op.mode;
        req_ch.chunk_x   <= op.cx;
        req_ch.chunk_y   <= op.cy;
        req_ch.layer     <= op.layer;
        req_ch.entry_ref <= op.handle;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_table_op(op));
        op_cnt++;
    endtask

    task automatic insert_tile(input logic [31:0] x, input logic [31:0] y,
                               input logic l, input logic [31:0] h);
        tile_op_t op;
        op.mode   = MODE_INSERT;
        op.cx     = x;
        op.cy     = y;
        op.layer  = l;
        op.handle = h;
        send_op(op);
    endtask

    task automatic clear_table();
        tile_op_t op;
        op.mode   = MODE_CLEAR;
        op.cx     = $urandom;
        op.cy     = $urandom;
        op.layer  = 1'($urandom_range(1));
        op.handle = $urandom;
        send_op(op);
    endtask

    // Stop sending and wait until every result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Capacity write, only with the block idle
    task automatic set_capacity(input logic [COUNT_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cap  = value;
        cfg_writes++;
    endtask

    // Coordinate mix: small range for collisions, full range, extremes
    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return 32'($urandom_range(16)) - 32'd8;
        else if (sel < 85)
            return $urandom;
        else
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
    endfunction

    // Insert request, often reusing a recent key (optionally aliased on x[31])
    task automatic make_insert(output tile_op_t op);
        op.mode   = MODE_INSERT;
        op.handle = $urandom;
        if (key_pool.size() != 0 && $urandom_range(99) < 35)
        begin
            op.cx    = key_pool[$urandom_range(key_pool.size() - 1)].cx;
            op.cy    = key_pool[$urandom_range(key_pool.size() - 1)].cy;
            op.layer = key_pool[$urandom_range(key_pool.size() - 1)].layer;
            if ($urandom_range(99) < 50)
            begin
                // exact repeat of one pool key
                op = key_pool[$urandom_range(key_pool.size() - 1)];
                op.handle = $urandom;
            end
            if ($urandom_range(99) < 20)
                op.cx[31] = ~op.cx[31];
        end
        else
        begin
            op.cx    = rand_coord();
            op.cy    = rand_coord();
            op.layer = 1'($urandom_range(1));
            key_pool.push_back(op);
            if (key_pool.size() > POOL_MAX)
                void'(key_pool.pop_front());
        end
    endtask

    // Result checker
    table_result_t want;
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d",
                       rsp_ch.status);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status,
                           rsp_ch.status);
                    err_cnt++;
                end
                if (rsp_ch.slot_index !== want.slot)
                begin
                    $error("slot_index: expected %0d, actual %0d", want.slot,
                           rsp_ch.slot_index);
                    err_cnt++;
                end
                if (rsp_ch.entries_used !== want.used)
                begin
                    $error("entries_used: expected %0d, actual %0d", want.used,
                           rsp_ch.entries_used);
                    err_cnt++;
                end
                case (want.status)
                    ST_INSERTED:  ins_cnt++;
                    ST_DUPLICATE: dup_cnt++;
                    ST_FULL:      full_cnt++;
                    default:      clr_cnt++;
                endcase
            end
        end
    end

    // Key extremes, duplicates, x[31] aliasing and clear at reset capacity
    task automatic test_directed_keys();
        insert_tile(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
        insert_tile(32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        insert_tile(32'h8000_0001, 32'h8000_0000, 1'b1, 32'h1234_5678);
        insert_tile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        insert_tile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
        insert_tile(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h5555_5555);
        insert_tile(32'h2AAA_AAAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
        // same key again
        insert_tile(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0BAD_0BAD);
        // x bit 31 drops out of the key
        insert_tile(32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0002);
        insert_tile(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0000_0003);
        // y differs only in its top bit: distinct key
        insert_tile(32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0000_0004);
        clear_table();
        insert_tile(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0005);
        insert_tile(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0006);
    endtask

    // Capacity zero, one, two and above the table depth
    task automatic test_capacity_limits();
        set_capacity(COUNT_W'(0));
        insert_tile(32'h0000_0001, 32'h0000_0002, 1'b0, 32'h0000_0007);
        insert_tile(32'hFFFF_FFF0, 32'h0000_0010, 1'b1, 32'h0000_0008);
        clear_table();
        set_capacity(COUNT_W'(1));
        insert_tile(32'h0000_0003, 32'h0000_0004, 1'b0, 32'h0000_0009);
        insert_tile(32'h0000_0005, 32'h0000_0006, 1'b1, 32'h0000_000A);
        // key present but table full: full wins
        insert_tile(32'h0000_0003, 32'h0000_0004, 1'b0, 32'h0000_000B);
        set_capacity(COUNT_W'(2047));
        clear_table();
        insert_tile(32'h0000_0003, 32'h0000_0004, 1'b0, 32'h0000_000C);
        insert_tile(32'hF000_0000, 32'h0FFF_FFFF, 1'b1, 32'h0000_000D);
        insert_tile(32'h0000_0003, 32'h0000_0004, 1'b0, 32'h0000_000E);
        set_capacity(COUNT_W'(2));
        clear_table();
        insert_tile(32'h0000_0011, 32'h0000_0012, 1'b0, 32'h0000_000F);
        insert_tile(32'h0000_0013, 32'h0000_0014, 1'b1, 32'h0000_0010);
        insert_tile(32'h0000_0015, 32'h0000_0016, 1'b0, 32'h0000_0011);
    endtask

    // Lower the capacity with entries stored above it, then raise it again
    task automatic test_capacity_shrink();
        int i;
        set_capacity(COUNT_W'(16));
        clear_table();
        for (i = 0; i < 10; i++)
            insert_tile(32'(i * 7 - 20), 32'(i * 3 + 1), i[0], $urandom);
        set_capacity(COUNT_W'(12));
        for (i = 0; i < 4; i++)
            insert_tile(32'(i * 5 + 100), 32'(-i), 1'b1, $urandom);
        set_capacity(COUNT_W'(16));
        for (i = 0; i < 4; i++)
            insert_tile(32'(i * 7 - 20), 32'(i * 3 + 1), i[0], $urandom);
    endtask

    // Random sequences: pick a capacity, usually clear, then fill with a mix
    task automatic test_random_traffic(input int idle, input int stall,
                                       input int num_ops);
        tile_op_t           op;
        int                 sent;
        int                 sel;
        int                 cap_eff;
        int                 len;
        int                 i;
        logic [COUNT_W-1:0] cap;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < num_ops)
        begin
            sel = $urandom_range(99);
            if (sel < 5)
                cap = '0;
            else if (sel < 12)
                cap = COUNT_W'($urandom_range(2047, 1025));
            else if (sel < 22)
                cap = COUNT_W'(TABLE_DEPTH);
            else if (sel < 28)
                cap = COUNT_W'(1);
            else
                cap = COUNT_W'($urandom_range(40, 2));
            set_capacity(cap);
            if ($urandom_range(99) < 80)
            begin
                clear_table();
                sent++;
            end
            cap_eff = (cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap);
            len = $urandom_range(((cap_eff > 40) ? 40 : cap_eff) + 4, 1);
            for (i = 0; i < len && sent < num_ops; i++)
            begin
                sel = $urandom_range(99);
                if (sel < 3)
                    clear_table();
                else if (sel < 10)
                    insert_tile($urandom, $urandom, 1'($urandom_range(1)), $urandom);
                else
                begin
                    make_insert(op);
                    send_op(op);
                end
                sent++;
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_INSERT;
        req_ch.chunk_x   = '0;
        req_ch.chunk_y   = '0;
        req_ch.layer     = 1'b0;
        req_ch.entry_ref = '0;
        rsp_ch.ready     = 1'b0;
        for (int n = 0; n < TABLE_DEPTH; n++)
            shadow_valid[n] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_keys();
        test_capacity_limits();
        test_capacity_shrink();
        test_random_traffic(0, 0, 270);
        test_random_traffic(59, 0, 270);
        test_random_traffic(0, 59, 270);
        test_random_traffic(8, 8, 270);

        drain_results();
        repeat (40) @(posedge clk);
        $display("Ran %0d operations across %0d capacity writes in %0d cycles",
                 op_cnt, cfg_writes, cycle_cnt);
        $display("Results: %0d inserted, %0d duplicate, %0d full, %0d cleared",
                 ins_cnt, dup_cnt, full_cnt, clr_cnt);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- hash_table_linear_probe_insert_top.f -----
rtl/htlp_pkg.sv
rtl/htlp_if.sv
rtl/hash_table_linear_probe_insert_top.sv
sim/tb_top.sv
